// ----- rtl/wna_pkg.sv -----
// ----------------------------------------------------------------------------
// wna_pkg
// Shared types and fixed field widths of the weighted neighbor average block.
// ----------------------------------------------------------------------------
`default_nettype none

package wna_pkg;

  // Fixed port widths of the payload fields
  localparam int COND_PORT_W  = 24;
  localparam int PRESS_PORT_W = 32;

  // Node jobs parked between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BOUNDARY = 2'd1,
    ST_ZERO     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/wna_queue.sv -----
// ----------------------------------------------------------------------------
// wna_queue
// Small register FIFO holding finished node sums until the divider takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module wna_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [DATA_W-1:0]           push_data,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [DATA_W-1:0]                head_data,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign empty     = (count_r == '0);
  assign head_data = mem[rd_ptr_r];
  assign count     = count_r;

  // Front side reserves space, so a push never meets a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CNT_W'(DEPTH)))
    else $error("wna_queue: push while full");

endmodule

`default_nettype wire

// ----- rtl/wna_front.sv -----
// ----------------------------------------------------------------------------
// wna_front
// Accepts link beats, counts links, multiplies and accumulates per node,
// and hands each finished node (sums, own pressure, class) to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wna_front #(
  parameter int MAX_LINKS        = 64,
  parameter int PRESSURE_BITS    = 32,
  parameter int CONDUCTANCE_BITS = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_push,
  output logic                                       in_full,
  input  wire logic [wna_pkg::COND_PORT_W-1:0]       in_conductance,
  input  wire logic signed [wna_pkg::PRESS_PORT_W-1:0] in_neighbor_pressure,
  input  wire logic signed [wna_pkg::PRESS_PORT_W-1:0] in_own_pressure,
  input  wire logic                                  in_is_boundary,
  input  wire logic                                  in_last_link,
  input  wire logic [wna_pkg::QUEUE_CNT_W-1:0]       q_count,
  output logic                                       q_push,
  output logic signed [CONDUCTANCE_BITS+PRESSURE_BITS+$clog2(MAX_LINKS)-1:0] q_wsum,
  output logic [CONDUCTANCE_BITS+$clog2(MAX_LINKS)-1:0] q_weight,
  output logic signed [PRESSURE_BITS-1:0]            q_own,
  output wna_pkg::status_t                           q_status
);

  import wna_pkg::*;

  localparam int CB     = CONDUCTANCE_BITS;
  localparam int PB     = PRESSURE_BITS;
  localparam int LG     = $clog2(MAX_LINKS);
  localparam int WSW    = CB + LG;
  localparam int PW     = CB + PB + LG;
  localparam int CNTW   = $clog2(MAX_LINKS + 1);
  localparam int SUMW   = QUEUE_CNT_W + 1;

  logic [CNTW-1:0]        link_cnt_r, link_cnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   accept, take;

  // stage 1: operands
  logic                   v1_r, last1_r;
  logic [CB-1:0]          cond1_r;
  logic signed [PB-1:0]   np1_r;
  logic signed [PB-1:0]   own1_r;
  status_t                stat1_r;

  // stage 2: product
  logic                   v2_r, last2_r;
  logic signed [CB+PB-1:0] prod2_r;
  logic [CB-1:0]          cond2_r;
  logic signed [PB-1:0]   own2_r;
  status_t                stat2_r;

  logic signed [CB+PB:0]  prod_full;
  logic signed [PW-1:0]   wsum_r, wsum_sum;
  logic [WSW-1:0]         wgt_r, wgt_sum;
  logic [SUMW-1:0]        reserved;

  // Lasts in flight each hold a queue slot
  assign reserved = SUMW'(q_count) + SUMW'(v1_r && last1_r) + SUMW'(v2_r && last2_r);
  assign in_full  = (reserved >= SUMW'(QUEUE_DEPTH));
  assign accept   = in_push && !in_full;
  assign take     = (link_cnt_r < CNTW'(MAX_LINKS));

  always_comb begin
    link_cnt_nxt = link_cnt_r;
    ovf_nxt      = ovf_r;
    if (accept) begin
      if (in_last_link) begin
        link_cnt_nxt = '0;
        ovf_nxt      = 1'b0;
      end else if (take) begin
        link_cnt_nxt = link_cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_cnt_r <= '0;
      ovf_r      <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      wsum_r     <= '0;
      wgt_r      <= '0;
    end else begin
      link_cnt_r <= link_cnt_nxt;
      ovf_r      <= ovf_nxt;
      v1_r       <= accept;
      v2_r       <= v1_r;
      if (v2_r) begin
        wsum_r <= last2_r ? '0 : wsum_sum;
        wgt_r  <= last2_r ? '0 : wgt_sum;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      last1_r <= in_last_link;
      cond1_r <= take ? in_conductance[CB-1:0] : '0;
      np1_r   <= in_neighbor_pressure[PB-1:0];
      own1_r  <= in_own_pressure[PB-1:0];
      if (in_is_boundary) begin
        stat1_r <= ST_BOUNDARY;
      end else if (ovf_r || !take) begin
        stat1_r <= ST_OVERFLOW;
      end else begin
        stat1_r <= ST_OK;
      end
    end
    if (v1_r) begin
      last2_r <= last1_r;
      prod2_r <= prod_full[CB+PB-1:0];
      cond2_r <= cond1_r;
      own2_r  <= own1_r;
      stat2_r <= stat1_r;
    end
  end

  assign prod_full = signed'({1'b0, cond1_r}) * np1_r;
  assign wsum_sum  = wsum_r + PW'(prod2_r);
  assign wgt_sum   = wgt_r + WSW'(cond2_r);

  assign q_push   = v2_r && last2_r;
  assign q_wsum   = wsum_sum;
  assign q_weight = wgt_sum;
  assign q_own    = own2_r;
  assign q_status = stat2_r;

  a_slot_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && last2_r) |-> (q_count < QUEUE_CNT_W'(QUEUE_DEPTH)))
    else $error("wna_front: node finished without a free queue slot");

endmodule

`default_nettype wire

// ----- rtl/wna_back.sv -----
// ----------------------------------------------------------------------------
// wna_back
// Takes node jobs from the queue, runs a radix-2 restoring divide of the
// weighted sum by the weight sum, and holds the result beat for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module wna_back #(
  parameter int MAX_LINKS        = 64,
  parameter int PRESSURE_BITS    = 32,
  parameter int CONDUCTANCE_BITS = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  q_empty,
  output logic                                       q_pop,
  input  wire logic signed [CONDUCTANCE_BITS+PRESSURE_BITS+$clog2(MAX_LINKS)-1:0] q_wsum,
  input  wire logic [CONDUCTANCE_BITS+$clog2(MAX_LINKS)-1:0] q_weight,
  input  wire logic signed [PRESSURE_BITS-1:0]       q_own,
  input  wire wna_pkg::status_t                      q_status,
  output logic                                       out_empty,
  input  wire logic                                  out_pop,
  output logic signed [wna_pkg::PRESS_PORT_W-1:0]    out_new_pressure,
  output wna_pkg::status_t                           out_status
);

  import wna_pkg::*;

  localparam int CB   = CONDUCTANCE_BITS;
  localparam int PB   = PRESSURE_BITS;
  localparam int LG   = $clog2(MAX_LINKS);
  localparam int WSW  = CB + LG;
  localparam int PW   = CB + PB + LG;
  localparam int ITW  = $clog2(PB);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic                   neg_r;
  logic signed [PW-1:0]   wsum_r;
  logic [WSW-1:0]         div_r;
  logic [WSW-1:0]         rem_r;
  logic [PB-1:0]          qsh_r;
  logic [ITW-1:0]         iter_r;
  status_t                stat_r;

  logic                   out_valid_r;
  logic signed [PRESS_PORT_W-1:0] out_press_r;
  status_t                out_stat_r;

  logic [PW-1:0]          mag;
  logic [WSW:0]           trial;
  logic                   ge;
  logic [WSW:0]           diff;
  logic signed [PB-1:0]   result;
  logic                   out_free;

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign mag      = neg_r ? PW'(-wsum_r) : PW'(wsum_r);
  assign trial    = {rem_r, qsh_r[PB-1]};
  assign ge       = (trial >= {1'b0, div_r});
  assign diff     = trial - {1'b0, div_r};
  assign result   = neg_r ? -signed'(qsh_r) : signed'(qsh_r);
  assign out_free = !out_valid_r || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // in S_DONE the output slot is refilled below whenever it frees up
      if (out_pop && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            wsum_r <= q_wsum;
            div_r  <= q_weight;
            if (q_status != ST_OK) begin
              qsh_r   <= q_own;
              neg_r   <= 1'b0;
              stat_r  <= q_status;
              state_r <= S_DONE;
            end else if (q_weight == '0) begin
              qsh_r   <= q_own;
              neg_r   <= 1'b0;
              stat_r  <= ST_ZERO;
              state_r <= S_DONE;
            end else begin
              neg_r   <= q_wsum[PW-1];
              stat_r  <= ST_OK;
              state_r <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          // quotient fits PB bits, so the top part starts below the divisor
          rem_r   <= mag[PW-1:PB];
          qsh_r   <= mag[PB-1:0];
          iter_r  <= ITW'(PB - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= ge ? diff[WSW-1:0] : trial[WSW-1:0];
          qsh_r  <= {qsh_r[PB-2:0], ge};
          iter_r <= iter_r - 1'b1;
          if (iter_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_press_r <= PRESS_PORT_W'(result);
            out_stat_r  <= stat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_new_pressure = out_press_r;
  assign out_status       = out_stat_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < div_r))
    else $error("wna_back: partial remainder not below divisor");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> (out_valid_r && $stable(out_press_r)
                                   && $stable(out_stat_r)))
    else $error("wna_back: waiting result changed");

endmodule

`default_nettype wire

// ----- rtl/weighted_neighbor_average_top.sv -----
// ----------------------------------------------------------------------------
// weighted_neighbor_average_top
// Relaxation node update: accumulates conductance-weighted neighbor pressure
// over a node's link beats and returns the weighted average in Q16.16.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            beat contents
//  -------  ---------  -------------------  ------------------------------------
//  in_      sink       in_push / in_full    conductance, neighbor_pressure,
//                                           own_pressure, is_boundary, last_link
//  out_     source     out_pop / out_empty  new_pressure, status
//
//  Link beats enter at one per cycle while in_full is low; the multiply
//  result is registered behind the input register, then accumulated.
//  A node that needs a divide passes through the divider steps in order
//  (pop, magnitude, one quotient bit per cycle, output load); passthrough
//  nodes go from pop to output load. The radix-2 divider sets the node rate.
//  Up to QUEUE_DEPTH finished nodes wait in the queue; in_full rises when
//  queued plus in-flight last beats fill it, so the front never stalls
//  mid-pipeline. A waiting result never blocks the divider from starting
//  the next node.
//  Synchronous active-low reset clears control; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_neighbor_average_top #(
  parameter int MAX_LINKS        = 64,
  parameter int PRESSURE_BITS    = 32,
  parameter int CONDUCTANCE_BITS = 24
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // link beats
  input  wire logic                                    in_push,
  output logic                                         in_full,
  input  wire logic [wna_pkg::COND_PORT_W-1:0]         in_conductance,
  input  wire logic signed [wna_pkg::PRESS_PORT_W-1:0] in_neighbor_pressure,
  input  wire logic signed [wna_pkg::PRESS_PORT_W-1:0] in_own_pressure,
  input  wire logic                                    in_is_boundary,
  input  wire logic                                    in_last_link,
  // node results
  output logic                                         out_empty,
  input  wire logic                                    out_pop,
  output logic signed [wna_pkg::PRESS_PORT_W-1:0]      out_new_pressure,
  output logic [1:0]                                   out_status
);

  import wna_pkg::*;

  localparam int LG     = $clog2(MAX_LINKS);
  localparam int WSW    = CONDUCTANCE_BITS + LG;
  localparam int PW     = CONDUCTANCE_BITS + PRESSURE_BITS + LG;
  localparam int JOB_W  = PW + WSW + PRESSURE_BITS + $bits(status_t);

  // front -> queue
  logic                            f_push;
  logic signed [PW-1:0]            f_wsum;
  logic [WSW-1:0]                  f_weight;
  logic signed [PRESSURE_BITS-1:0] f_own;
  status_t                         f_status;
  logic [QUEUE_CNT_W-1:0]          q_count;

  // queue -> back
  logic                            q_empty;
  logic                            q_pop;
  logic [JOB_W-1:0]                q_head;
  logic [JOB_W-1:0]                f_job;

  status_t                         b_status;

  wna_front #(
    .MAX_LINKS        (MAX_LINKS),
    .PRESSURE_BITS    (PRESSURE_BITS),
    .CONDUCTANCE_BITS (CONDUCTANCE_BITS)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_conductance       (in_conductance),
    .in_neighbor_pressure (in_neighbor_pressure),
    .in_own_pressure      (in_own_pressure),
    .in_is_boundary       (in_is_boundary),
    .in_last_link         (in_last_link),
    .q_count              (q_count),
    .q_push               (f_push),
    .q_wsum               (f_wsum),
    .q_weight             (f_weight),
    .q_own                (f_own),
    .q_status             (f_status)
  );

  // job word: weighted sum, weight sum, own pressure, class
  assign f_job = {f_wsum, f_weight, f_own, f_status};

  wna_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_job),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_data (q_head),
    .count     (q_count)
  );

  wna_back #(
    .MAX_LINKS        (MAX_LINKS),
    .PRESSURE_BITS    (PRESSURE_BITS),
    .CONDUCTANCE_BITS (CONDUCTANCE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_wsum           (q_head[JOB_W-1 -: PW]),
    .q_weight         (q_head[JOB_W-PW-1 -: WSW]),
    .q_own            (q_head[$bits(status_t) +: PRESSURE_BITS]),
    .q_status         (status_t'(q_head[$bits(status_t)-1:0])),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_new_pressure (out_new_pressure),
    .out_status       (b_status)
  );

  assign out_status = b_status;

endmodule

`default_nettype wire

// ----- test/tb_weighted_neighbor_average_top.sv -----
// ----------------------------------------------------------------------------
// tb_weighted_neighbor_average_top
// Self-checking bench for the relaxation node update block. Link beats are
// streamed from a backlog, each accepted beat is folded into a local model of
// the accumulators, and every node result popped from the block is checked
// against the oldest predicted node update.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_weighted_neighbor_average_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wna_pkg::*;

  localparam int MAX_LINKS        = 64;
  localparam int PRESSURE_BITS    = 32;
  localparam int CONDUCTANCE_BITS = 24;
  localparam int LINK_TARGET      = 1500;
  localparam int QUIET_LIMIT      = 4000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES    = 120;   // divider plus output register, with margin

  // pressure picks
  localparam int PM_RANDOM  = 0;
  localparam int PM_EXTREME = 1;
  // conductance picks
  localparam int CM_RANDOM = 0;
  localparam int CM_SMALL  = 1;
  localparam int CM_ZERO   = 2;
  localparam int CM_MAX    = 3;

  typedef struct {
    logic [COND_PORT_W-1:0]         conductance;
    logic signed [PRESS_PORT_W-1:0] neighbor_pressure;
    logic signed [PRESS_PORT_W-1:0] own_pressure;
    logic                           is_boundary;
    logic                           last_link;
    bit                             drain_first;  // hold until all results are back
  } link_t;

  typedef struct {
    logic signed [PRESS_PORT_W-1:0] new_pressure;
    status_t                        status;
  } node_update_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n = 1'b0;

  logic                           in_push              = 1'b0;
  logic                           in_full;
  logic [COND_PORT_W-1:0]         in_conductance       = '0;
  logic signed [PRESS_PORT_W-1:0] in_neighbor_pressure = '0;
  logic signed [PRESS_PORT_W-1:0] in_own_pressure      = '0;
  logic                           in_is_boundary       = 1'b0;
  logic                           in_last_link         = 1'b0;
  logic                           out_empty;
  logic                           out_pop              = 1'b0;
  logic signed [PRESS_PORT_W-1:0] out_new_pressure;
  logic [1:0]                     out_status;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  weighted_neighbor_average_top #(
    .MAX_LINKS       (MAX_LINKS),
    .PRESSURE_BITS   (PRESSURE_BITS),
    .CONDUCTANCE_BITS(CONDUCTANCE_BITS)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_conductance      (in_conductance),
    .in_neighbor_pressure(in_neighbor_pressure),
    .in_own_pressure     (in_own_pressure),
    .in_is_boundary      (in_is_boundary),
    .in_last_link        (in_last_link),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_new_pressure    (out_new_pressure),
    .out_status          (out_status)
  );

  // Handshakes as seen at the coming edge
  wire link_beat = in_push && !in_full;
  wire node_beat = out_pop && !out_empty;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  link_t        link_backlog[$];      // beats not yet accepted
  node_update_t node_updates_due[$];  // predicted results, oldest first
  int           links_planned = 0;
  int           links_sent    = 0;
  int           fail_count    = 0;
  int           quiet_cycles  = 0;

  // Local copy of the node accumulators
  longint       weighted_total = 0;   // Q30.32 sum of conductance * pressure
  logic [29:0]  weight_total   = '0;  // Q14.16 sum of conductance
  int           links_in_node  = 0;
  bit           link_overrun   = 1'b0;

  // Idle odds per side: sender light / receiver heavy, then swapped, then none
  function automatic int idle_pct(input bit rx_side);
    if (links_sent < links_planned / 3) return rx_side ? 83 : 25;
    if (links_sent < 2 * links_planned / 3) return rx_side ? 25 : 83;
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: fold one accepted link beat into the node accumulators and,
  // on the node's last beat, queue the expected node update.
  // --------------------------------------------------------------------------
  task automatic fold_link(input link_t l);
    node_update_t u;
    longint       quotient;
    if (links_in_node < MAX_LINKS) begin
      weighted_total = weighted_total +
                       longint'(l.conductance) * longint'(l.neighbor_pressure);
      weight_total   = weight_total + 30'(l.conductance);
      links_in_node  = links_in_node + 1;
    end else begin
      // link beyond the limit: dropped, node gets flagged
      link_overrun = 1'b1;
    end
    if (l.last_link) begin
      u.new_pressure = l.own_pressure;
      if (l.is_boundary) begin
        u.status = ST_BOUNDARY;
      end else if (link_overrun) begin
        u.status = ST_OVERFLOW;
      end else if (weight_total == '0) begin
        u.status = ST_ZERO;
      end else begin
        // signed divide truncates toward zero
        quotient       = weighted_total / longint'(weight_total);
        u.new_pressure = quotient[PRESS_PORT_W-1:0];
        u.status       = ST_OK;
      end
      node_updates_due.push_back(u);
      weighted_total = 0;
      weight_total   = '0;
      links_in_node  = 0;
      link_overrun   = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_link(input logic [COND_PORT_W-1:0] cond,
                          input logic signed [PRESS_PORT_W-1:0] np,
                          input logic signed [PRESS_PORT_W-1:0] op,
                          input logic bnd, input logic last, input bit drain);
    link_t l;
    l.conductance       = cond;
    l.neighbor_pressure = np;
    l.own_pressure      = op;
    l.is_boundary       = bnd;
    l.last_link         = last;
    l.drain_first       = drain;
    link_backlog.push_back(l);
  endtask

  function automatic logic signed [PRESS_PORT_W-1:0] pick_pressure(input int mode);
    logic signed [PRESS_PORT_W-1:0] p;
    p = $urandom;
    if (mode == PM_EXTREME) begin
      case ($urandom_range(4))
        0: p = 32'sh8000_0000;
        1: p = 32'sh7FFF_FFFF;
        2: p = '0;
        3: p = -32'sd1;
        default: p = 32'sd1;
      endcase
    end
    return p;
  endfunction

  function automatic logic [COND_PORT_W-1:0] pick_conductance(input int mode);
    case (mode)
      CM_SMALL: return COND_PORT_W'($urandom_range(255));
      CM_ZERO:  return '0;
      CM_MAX:   return ($urandom_range(3) != 0) ? '1 : COND_PORT_W'($urandom);
      default:  return COND_PORT_W'($urandom);
    endcase
  endfunction

  // One node of n links with random content; only the last beat's boundary
  // bit and own pressure matter, the others are scrambled on purpose.
  task automatic add_node(input int n, input bit bnd, input bit drain);
    int cmode;
    int pmode;
    int r;
    r     = $urandom_range(99);
    cmode = (r < 8) ? CM_ZERO : (r < 20) ? CM_SMALL : (r < 26) ? CM_MAX : CM_RANDOM;
    pmode = ($urandom_range(9) == 0) ? PM_EXTREME : PM_RANDOM;
    for (int i = 0; i < n; i++) begin
      add_link(pick_conductance(cmode), pick_pressure(pmode), pick_pressure(PM_RANDOM),
               (i == n - 1) ? bnd : 1'($urandom), i == n - 1, drain && i == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Link driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_links
    bit hold_now;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (link_beat) begin
        fold_link(link_backlog.pop_front());
        links_sent = links_sent + 1;
      end
      // a beat stalled by full stays on the bus untouched
      if (!(in_push && in_full)) begin
        hold_now = link_backlog.size() == 0 ||
                   $urandom_range(99) < idle_pct(1'b0) ||
                   (link_backlog[0].drain_first && node_updates_due.size() != 0);
        if (hold_now) begin
          in_push <= 1'b0;
        end else begin
          in_push              <= 1'b1;
          in_conductance       <= link_backlog[0].conductance;
          in_neighbor_pressure <= link_backlog[0].neighbor_pressure;
          in_own_pressure      <= link_backlog[0].own_pressure;
          in_is_boundary       <= link_backlog[0].is_boundary;
          in_last_link         <= link_backlog[0].last_link;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_nodes
    node_update_t u;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (node_beat) begin
        if (node_updates_due.size() == 0) begin
          $error("unexpected node result: new_pressure %0d status %0d",
                 out_new_pressure, out_status);
          fail_count = fail_count + 1;
        end else begin
          u = node_updates_due.pop_front();
          if (out_new_pressure !== u.new_pressure) begin
            $error("new_pressure: expected %0d, actual %0d", u.new_pressure,
                   out_new_pressure);
            fail_count = fail_count + 1;
          end
          if (out_status !== u.status) begin
            $error("status: expected %0d, actual %0d", u.status, out_status);
            fail_count = fail_count + 1;
          end
        end
      end
      out_pop <= $urandom_range(99) >= idle_pct(1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: no beat on either side for too long ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (!rst_n || link_beat || node_beat) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : run
    int  n;
    int  r;
    int  next_marker;
    // --- directed nodes ---
    // full-scale conductance with the pressure extremes: exact passthrough
    add_link('1, 32'sh7FFF_FFFF, 32'sd5, 1'b0, 1'b1, 1'b0);
    add_link('1, 32'sh8000_0000, 32'sd5, 1'b0, 1'b1, 1'b0);
    // zero conductance on a single link
    add_link('0, 32'sh1234_5678, -32'sd77, 1'b0, 1'b1, 1'b0);
    // -1/2 must truncate to zero, not -1
    add_link(24'd1, -32'sd1, 32'sd9, 1'b0, 1'b0, 1'b0);
    add_link(24'd1, 32'sd0, 32'sd9, 1'b0, 1'b1, 1'b0);
    // -7/3 gives -2
    add_link(24'd1, -32'sd7, 32'sd0, 1'b1, 1'b0, 1'b0);
    add_link(24'd1, 32'sd0, 32'sd0, 1'b1, 1'b0, 1'b0);
    add_link(24'd1, 32'sd0, 32'sd3, 1'b0, 1'b1, 1'b0);
    // boundary with real weights, and boundary with no weight
    add_link(24'h01_0000, 32'sh0002_0000, 32'sh8000_0000, 1'b1, 1'b1, 1'b0);
    add_link('0, 32'sh0002_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b0);
    // boundary bit on every link, the last included: boundary node
    add_link(24'h00_8000, 32'sh7FFF_FFFF, 32'sd1, 1'b1, 1'b0, 1'b0);
    add_link(24'hFF_FFFF, 32'sh8000_0000, 32'sd2, 1'b1, 1'b1, 1'b0);
    // mixed extremes, then an own pressure change on the last link only
    add_link('1, 32'sh8000_0000, 32'sd0, 1'b0, 1'b0, 1'b0);
    add_link('1, 32'sh7FFF_FFFF, 32'sd0, 1'b0, 1'b0, 1'b0);
    add_link(24'd1, 32'sh8000_0000, 32'sd0, 1'b0, 1'b0, 1'b0);
    add_link('0, 32'sh7FFF_FFFF, -32'sd1, 1'b0, 1'b1, 1'b0);

    // --- random nodes ---
    // exactly the link limit, one beyond, and beyond with a boundary finish
    add_node(MAX_LINKS, 1'b0, 1'b1);
    add_node(MAX_LINKS + 1, 1'b0, 1'b0);
    add_node(MAX_LINKS + 3, 1'b1, 1'b0);
    next_marker = LINK_TARGET / 3;
    while (link_backlog.size() < LINK_TARGET) begin
      r = $urandom_range(99);
      n = (r < 3) ? $urandom_range(MAX_LINKS + 6, MAX_LINKS - 4) : $urandom_range(8, 1);
      // drain at each idle phase change and now and then at random
      if (link_backlog.size() >= next_marker) begin
        add_node(n, $urandom_range(9) == 0, 1'b1);
        next_marker = next_marker + LINK_TARGET / 3;
      end else begin
        add_node(n, $urandom_range(9) == 0, $urandom_range(49) == 0);
      end
    end
    links_planned = link_backlog.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (link_backlog.size() != 0 || in_push) @(posedge clk);
    while (node_updates_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (node_updates_due.size() != 0) begin
      $error("%0d node results never arrived", node_updates_due.size());
      fail_count = fail_count + 1;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
